>>> sv/cau_pkg.sv
`default_nettype none
package cau_pkg;

   // Defaults for the top-level parameters.
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Operation kinds.
   localparam logic [2:0] KIND_ADD = 3'd0;
   localparam logic [2:0] KIND_SUB = 3'd1;
   localparam logic [2:0] KIND_MUL = 3'd2;
   localparam logic [2:0] KIND_DIV = 3'd3;
   localparam logic [2:0] KIND_CMP = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   // Quotient bits kept by the divider and the width of its remainder.
   localparam int Q_BITS = 33;
   localparam int DIV_W  = 64 + Q_BITS;

   // One classified item as it waits between the front and the back.
   typedef struct packed {
      logic        need_mul;
      logic        is_div;
      logic [31:0] ar;
      logic [31:0] ai;
      logic [31:0] br;
      logic [31:0] bi;
      logic [31:0] res_r;
      logic [31:0] res_i;
      logic        eq;
      logic [1:0]  st;
   } item_type;

   // Saturates a sign and magnitude pair to 32 bits; bit 32 flags saturation.
   function automatic logic [32:0] sat_part(input logic neg, input logic [64:0] mag);
      logic [32:0] r;
      if (neg) begin
         if (mag > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(~mag + 65'd1)};
      end else begin
         if (mag > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/cau_front.sv
`default_nettype none
module cau_front import cau_pkg::*; (
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   output item_type           push_item
);

   logic signed [32:0] sum_r;
   logic signed [32:0] sum_i;
   logic [32:0]        mag_r;
   logic [32:0]        mag_i;
   logic [32:0]        sat_r;
   logic [32:0]        sat_i;

   // Add and subtract finish here; the magnitude is saturated per part.
   always_comb begin
      if (req_kind == KIND_SUB) begin
         sum_r = 33'(req_a_real) - 33'(req_b_real);
         sum_i = 33'(req_a_imag) - 33'(req_b_imag);
      end else begin
         sum_r = 33'(req_a_real) + 33'(req_b_real);
         sum_i = 33'(req_a_imag) + 33'(req_b_imag);
      end
      mag_r = sum_r[32] ? 33'(-sum_r) : 33'(sum_r);
      mag_i = sum_i[32] ? 33'(-sum_i) : 33'(sum_i);
      sat_r = sat_part(sum_r[32], 65'(mag_r));
      sat_i = sat_part(sum_i[32], 65'(mag_i));
   end

   // Classify the item and fill in every result that needs no multiplier.
   always_comb begin
      push_item    = '0;
      push_item.ar = req_a_real;
      push_item.ai = req_a_imag;
      push_item.br = req_b_real;
      push_item.bi = req_b_imag;
      case (req_kind)
         KIND_ADD, KIND_SUB: begin
            push_item.res_r = sat_r[31:0];
            push_item.res_i = sat_i[31:0];
            push_item.st    = (sat_r[32] | sat_i[32]) ? ST_SAT : ST_OK;
         end
         KIND_MUL: begin
            push_item.need_mul = 1'b1;
         end
         KIND_DIV: begin
            if (req_b_real == 32'sd0 && req_b_imag == 32'sd0) begin
               push_item.st = ST_DIV0;
            end else begin
               push_item.need_mul = 1'b1;
               push_item.is_div   = 1'b1;
            end
         end
         KIND_CMP: begin
            push_item.eq = (req_a_real == req_b_real) && (req_a_imag == req_b_imag);
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

>>> sv/cau_queue.sv
`default_nettype none
module cau_queue import cau_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     full,
   input  logic     pop_ready,
   output logic     pop_valid,
   output item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

>>> sv/cau_back.sv
`default_nettype none
module cau_back import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_real,
   output logic signed [31:0] rsp_res_imag,
   output logic               rsp_equal_flag,
   output logic [1:0]         rsp_status
);

   typedef struct packed {
      logic              is_div;
      logic [31:0]       res_r;
      logic [31:0]       res_i;
      logic              eq;
      logic [1:0]        st;
      logic              neg_r;
      logic              neg_i;
      logic              ovf_r;
      logic              ovf_i;
      logic [DIV_W-1:0]  rem_r;
      logic [DIV_W-1:0]  rem_i;
      logic [63:0]       n;
      logic [Q_BITS-1:0] q_r;
      logic [Q_BITS-1:0] q_i;
   } div_type;

   logic               adv;
   // Product stage.
   logic               v0_ff;
   item_type           it0_ff;
   logic signed [63:0] p_arbr_ff, p_aibi_ff, p_arbi_ff, p_aibr_ff, p_brbr_ff, p_bibi_ff;
   // Sum stage.
   logic               v1_ff;
   item_type           it1_ff;
   logic               neg_r1_ff, neg_i1_ff;
   logic [63:0]        mag_r1_ff, mag_i1_ff, n1_ff;
   logic signed [64:0] sum_r, sum_i;
   // Divider stages.
   logic               vld_ff [Q_BITS+1];
   div_type            ds_ff  [Q_BITS+1];
   div_type            ds_in  [Q_BITS+1];
   logic [32:0]        mr, mi, fr, fi;
   // Output register.
   logic               rsp_valid_ff;
   logic [31:0]        res_r_ff, res_i_ff;
   logic               eq_ff;
   logic [1:0]         st_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign pop_ready = adv;

   // Valid bits of every stage advance together.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         vld_ff[0]    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= pop_valid;
         v1_ff        <= v0_ff;
         vld_ff[0]    <= v1_ff;
         rsp_valid_ff <= vld_ff[Q_BITS];
      end
   end

   // Six signed products cover both multiply and divide.
   always_ff @(posedge clock) begin
      if (adv) begin
         it0_ff    <= pop_item;
         p_arbr_ff <= $signed(pop_item.ar) * $signed(pop_item.br);
         p_aibi_ff <= $signed(pop_item.ai) * $signed(pop_item.bi);
         p_arbi_ff <= $signed(pop_item.ar) * $signed(pop_item.bi);
         p_aibr_ff <= $signed(pop_item.ai) * $signed(pop_item.br);
         p_brbr_ff <= $signed(pop_item.br) * $signed(pop_item.br);
         p_bibi_ff <= $signed(pop_item.bi) * $signed(pop_item.bi);
      end
   end

   // Exact numerator sums, split into sign and magnitude.
   always_comb begin
      if (it0_ff.is_div) begin
         sum_r = 65'(p_arbr_ff) + 65'(p_aibi_ff);
         sum_i = 65'(p_aibr_ff) - 65'(p_arbi_ff);
      end else begin
         sum_r = 65'(p_arbr_ff) - 65'(p_aibi_ff);
         sum_i = 65'(p_arbi_ff) + 65'(p_aibr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff    <= it0_ff;
         neg_r1_ff <= sum_r[64];
         neg_i1_ff <= sum_i[64];
         mag_r1_ff <= sum_r[64] ? 64'(-sum_r) : 64'(sum_r);
         mag_i1_ff <= sum_i[64] ? 64'(-sum_i) : 64'(sum_i);
         n1_ff     <= 64'($unsigned(p_brbr_ff)) + 64'($unsigned(p_bibi_ff));
      end
   end

   // Multiply results finish here; divides get a scaled remainder and a range check.
   always_comb begin
      mr              = sat_part(neg_r1_ff, 65'(mag_r1_ff >> FRAC_BITS));
      mi              = sat_part(neg_i1_ff, 65'(mag_i1_ff >> FRAC_BITS));
      ds_in[0]        = '0;
      ds_in[0].is_div = it1_ff.is_div;
      ds_in[0].res_r  = it1_ff.res_r;
      ds_in[0].res_i  = it1_ff.res_i;
      ds_in[0].eq     = it1_ff.eq;
      ds_in[0].st     = it1_ff.st;
      ds_in[0].neg_r  = neg_r1_ff;
      ds_in[0].neg_i  = neg_i1_ff;
      ds_in[0].n      = n1_ff;
      if (it1_ff.need_mul && !it1_ff.is_div) begin
         ds_in[0].res_r = mr[31:0];
         ds_in[0].res_i = mi[31:0];
         ds_in[0].st    = (mr[32] | mi[32]) ? ST_SAT : ST_OK;
      end
      if (it1_ff.is_div) begin
         ds_in[0].rem_r = DIV_W'(mag_r1_ff) << FRAC_BITS;
         ds_in[0].rem_i = DIV_W'(mag_i1_ff) << FRAC_BITS;
         ds_in[0].ovf_r = ds_in[0].rem_r >= (DIV_W'(n1_ff) << Q_BITS);
         ds_in[0].ovf_i = ds_in[0].rem_i >= (DIV_W'(n1_ff) << Q_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) ds_ff[0] <= ds_in[0];
   end

   // Restoring divider: one quotient bit per stage, most significant first.
   for (genvar j = 0; j < Q_BITS; j++) begin : g_div
      localparam int K = Q_BITS - 1 - j;

      always_comb begin
         logic [DIV_W-1:0] trial;
         trial      = DIV_W'(ds_ff[j].n) << K;
         ds_in[j+1] = ds_ff[j];
         if (ds_ff[j].rem_r >= trial) begin
            ds_in[j+1].rem_r  = ds_ff[j].rem_r - trial;
            ds_in[j+1].q_r[K] = 1'b1;
         end
         if (ds_ff[j].rem_i >= trial) begin
            ds_in[j+1].rem_i  = ds_ff[j].rem_i - trial;
            ds_in[j+1].q_i[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j+1] <= 1'b0;
         else if (adv) vld_ff[j+1] <= vld_ff[j];
      end

      always_ff @(posedge clock) begin
         if (adv) ds_ff[j+1] <= ds_in[j+1];
      end
   end

   // Quotient saturation and the output register.
   always_comb begin
      fr = sat_part(ds_ff[Q_BITS].neg_r,
                    ds_ff[Q_BITS].ovf_r ? (65'd1 << Q_BITS) : 65'(ds_ff[Q_BITS].q_r));
      fi = sat_part(ds_ff[Q_BITS].neg_i,
                    ds_ff[Q_BITS].ovf_i ? (65'd1 << Q_BITS) : 65'(ds_ff[Q_BITS].q_i));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (ds_ff[Q_BITS].is_div) begin
            res_r_ff <= fr[31:0];
            res_i_ff <= fi[31:0];
            eq_ff    <= 1'b0;
            st_ff    <= (fr[32] | fi[32]) ? ST_SAT : ST_OK;
         end else begin
            res_r_ff <= ds_ff[Q_BITS].res_r;
            res_i_ff <= ds_ff[Q_BITS].res_i;
            eq_ff    <= ds_ff[Q_BITS].eq;
            st_ff    <= ds_ff[Q_BITS].st;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_real   = res_r_ff;
   assign rsp_res_imag   = res_i_ff;
   assign rsp_equal_flag = eq_ff;
   assign rsp_status     = st_ff;

   // A division by zero gives zero parts and no equality.
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIV0 |->
         rsp_res_real == 32'sd0 && rsp_res_imag == 32'sd0 && !rsp_equal_flag)
      else $error("division by zero result not cleared");

   // Equality is only reported by a compare, which never saturates.
   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal_flag |->
         rsp_status == ST_OK && rsp_res_real == 32'sd0 && rsp_res_imag == 32'sd0)
      else $error("equality flag with nonzero result");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

>>> sv/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed fixed-point operands.
// The req_ channel takes one item per cycle unless stalled: an operation
// kind (add, subtract, multiply, divide, compare) and two complex operands.
// An item is taken at an edge where req_valid is high and req_stall is low.
// The rsp_ channel returns exactly one result item per request, in order:
// both result parts, the equality flag and a status code.
// From acceptance to rsp_valid, an item goes from the queue entry straight
// into the product stage, then the sum stage, a range-check stage, one
// divider stage for each of the 33 quotient bits, and the output register.
// Throughput is one item per cycle while rsp_stall holds no result, set by
// the fully pipelined divider.
// When rsp_stall holds a result, the back pipeline freezes and the input
// queue keeps taking items until it is full; req_stall then rises.
// A synchronous reset empties the queue and the pipeline; no result is
// pending after it.
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_real,
   output logic signed [31:0] rsp_res_imag,
   output logic               rsp_equal_flag,
   output logic [1:0]         rsp_status
);

   item_type push_item;
   item_type pop_item;
   logic     full;
   logic     pop_valid;
   logic     pop_ready;

   assign req_stall = full;

   cau_front u_front (
      .req_kind   (req_kind),
      .req_a_real (req_a_real),
      .req_a_imag (req_a_imag),
      .req_b_real (req_b_real),
      .req_b_imag (req_b_imag),
      .push_item  (push_item)
   );

   cau_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_item  (push_item),
      .full       (full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_item       (pop_item),
      .pop_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_res_real   (rsp_res_real),
      .rsp_res_imag   (rsp_res_imag),
      .rsp_equal_flag (rsp_equal_flag),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire
